@@ rtl/p1305_pkg.sv @@
`default_nettype none

package p1305_pkg;

  localparam int NumLimbs   = 5;
  localparam int LimbW      = 26;
  localparam int AccW       = LimbW + 1;
  localparam int OpW        = LimbW + 2;
  localparam int CoefW      = LimbW + 3;
  localparam int ProdW      = OpW + CoefW;
  localparam int SumW       = ProdW + 3;
  localparam int NhW        = SumW - LimbW + 4;
  localparam int MsgW       = NumLimbs * LimbW;
  localparam int TagW       = 128;
  localparam int BlockBytes = 16;
  localparam int P1305Fold  = 5;

  localparam logic [TagW-1:0] ClampMask = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
  localparam logic [7:0]      PadByte   = 8'h01;
  localparam logic [2:0]      LastMulStep = 3'(NumLimbs);

  typedef enum logic [1:0] {
    REG_R_LOW    = 2'd0,
    REG_R_HIGH   = 2'd1,
    REG_PAD_LOW  = 2'd2,
    REG_PAD_HIGH = 2'd3
  } p1305_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CARRY1,
    ST_CARRY2,
    ST_FOLD,
    ST_REDUCE,
    ST_SELECT,
    ST_PAD
  } p1305_state_e;

  typedef struct packed {
    logic [TagW-1:0] r;
    logic [TagW-1:0] s;
  } p1305_key_t;

  typedef struct packed {
    logic [MsgW-1:0] msg;
    logic            absorb;
    logic            last;
  } p1305_item_t;

endpackage

`default_nettype wire

@@ rtl/p1305_front.sv @@
`default_nettype none

module p1305_front (
  input  wire logic [63:0]          block_low_i,
  input  wire logic [63:0]          block_high_i,
  input  wire logic [4:0]           block_bytes_i,
  input  wire logic                 is_last_i,
  output p1305_pkg::p1305_item_t    item_o
);
  import p1305_pkg::*;

  logic [4:0]      nbytes;
  logic            short_blk;
  logic [TagW-1:0] padded;

  assign nbytes    = (block_bytes_i > 5'(BlockBytes)) ? 5'(BlockBytes) : block_bytes_i;
  assign short_blk = is_last_i && (nbytes < 5'(BlockBytes));

  always_comb begin
    padded = {block_high_i, block_low_i};
    if (short_blk) begin
      for (int b = 0; b < BlockBytes; b++) begin
        if (5'(b) == nbytes) begin
          padded[8*b +: 8] = PadByte;
        end else if (5'(b) > nbytes) begin
          padded[8*b +: 8] = '0;
        end
      end
    end
  end

  assign item_o.msg    = {1'b0, !short_blk, padded};
  assign item_o.absorb = (nbytes != '0);
  assign item_o.last   = is_last_i;

endmodule

`default_nettype wire

@@ rtl/p1305_fifo.sv @@
`default_nettype none

module p1305_fifo #(
  parameter int Depth = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire p1305_pkg::p1305_item_t item_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output p1305_pkg::p1305_item_t    item_o,
  output logic                      empty_o
);
  import p1305_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  p1305_item_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign push    = push_i && !full_o;
  assign pop     = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Queue count exceeds its depth.");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("Queue count did not follow a push.");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 1'b1)
    else $error("Queue count did not follow a pop.");

endmodule

`default_nettype wire

@@ rtl/p1305_back.sv @@
`default_nettype none

module p1305_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire p1305_pkg::p1305_key_t  key_i,
  input  wire p1305_pkg::p1305_item_t item_i,
  input  wire logic                 item_valid_i,
  output logic                      item_pop_o,
  output logic                      tag_valid_o,
  input  wire logic                 tag_ready_i,
  output logic [127:0]              tag_o
);
  import p1305_pkg::*;

  localparam int HeadroomW = 12;

  p1305_state_e     state_q, state_d;
  logic [2:0]       mul_cnt_q, mul_cnt_d;
  logic [2:0]       mul_idx;
  logic             last_q, last_d;
  logic             tag_valid_q, tag_valid_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic [OpW-1:0]   a_q   [NumLimbs];
  logic [OpW-1:0]   a_d   [NumLimbs];
  logic [ProdW-1:0] p_q   [NumLimbs];
  logic [ProdW-1:0] p_d   [NumLimbs];
  logic [SumW-1:0]  d_q   [NumLimbs];
  logic [SumW-1:0]  d_d   [NumLimbs];
  logic [NhW-1:0]   nh_q  [NumLimbs];
  logic [NhW-1:0]   nh_d  [NumLimbs];
  logic [AccW-1:0]  acc_q [NumLimbs];
  logic [AccW-1:0]  acc_d [NumLimbs];
  logic [LimbW-1:0] r_q   [NumLimbs];
  logic [CoefW-1:0] r5_q  [NumLimbs];
  logic [CoefW-1:0] coef_tab [NumLimbs][NumLimbs];
  logic [MsgW:0]    v_q, v_d, w_q, w_d, fold_b, sel_g;
  logic [MsgW-1:0]  fold_a, r_clamped;
  logic [TagW-1:0]  f_q, f_d;
  logic [OpW-1:0]   a_sel;
  logic [NhW-1:0]   wrap1;
  logic [AccW-1:0]  wrap2;
  logic             tag_write;
  logic             acc_zero, acc_bound_ok;

  assign r_clamped = {2'b00, key_i.r & ClampMask};

  for (genvar k = 0; k < NumLimbs; k++) begin : g_limb
    assign fold_a[k*LimbW +: LimbW] = acc_q[k][LimbW-1:0];
    for (genvar c = 0; c < NumLimbs; c++) begin : g_coef
      if (k >= c) begin : g_direct
        assign coef_tab[c][k] = {{(CoefW-LimbW){1'b0}}, r_q[k-c]};
      end else begin : g_wrapped
        assign coef_tab[c][k] = r5_q[k-c+NumLimbs];
      end
    end
  end

  always_comb begin
    fold_b = '0;
    for (int k = 0; k < NumLimbs; k++) begin
      fold_b[(k+1)*LimbW] = acc_q[k][LimbW];
    end
  end

  assign mul_idx = (mul_cnt_q == LastMulStep) ? '0 : mul_cnt_q;
  assign a_sel   = a_q[mul_idx];
  assign wrap1   = NhW'(d_q[NumLimbs-1][SumW-1:LimbW]);
  assign wrap2   = AccW'(nh_q[NumLimbs-1][NhW-1:LimbW]);
  assign sel_g   = w_q + (MsgW+1)'(P1305Fold);
  assign tag_write = (state_q == ST_PAD) && (!tag_valid_q || tag_ready_i);

  always_comb begin
    state_d     = state_q;
    mul_cnt_d   = mul_cnt_q;
    last_d      = last_q;
    a_d         = a_q;
    p_d         = p_q;
    d_d         = d_q;
    nh_d        = nh_q;
    acc_d       = acc_q;
    v_d         = v_q;
    w_d         = w_q;
    f_d         = f_q;
    tag_d       = tag_q;
    tag_valid_d = tag_valid_q && !tag_ready_i;
    item_pop_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          last_d     = item_i.last;
          if (item_i.absorb) begin
            for (int k = 0; k < NumLimbs; k++) begin
              a_d[k] = OpW'(acc_q[k]) + OpW'(item_i.msg[k*LimbW +: LimbW]);
            end
            mul_cnt_d = '0;
            state_d   = ST_MUL;
          end else if (item_i.last) begin
            state_d = ST_FOLD;
          end
        end
      end
      ST_MUL: begin
        if (mul_cnt_q != LastMulStep) begin
          for (int k = 0; k < NumLimbs; k++) begin
            p_d[k] = ProdW'(a_sel) * ProdW'(coef_tab[mul_idx][k]);
          end
        end
        if (mul_cnt_q != '0) begin
          for (int k = 0; k < NumLimbs; k++) begin
            d_d[k] = ((mul_cnt_q == 3'd1) ? '0 : d_q[k]) + SumW'(p_q[k]);
          end
        end
        if (mul_cnt_q == LastMulStep) begin
          state_d = ST_CARRY1;
        end else begin
          mul_cnt_d = mul_cnt_q + 1'b1;
        end
      end
      ST_CARRY1: begin
        nh_d[0] = NhW'(d_q[0][LimbW-1:0]) + (wrap1 << 2) + wrap1;
        for (int k = 1; k < NumLimbs; k++) begin
          nh_d[k] = NhW'(d_q[k][LimbW-1:0]) + NhW'(d_q[k-1][SumW-1:LimbW]);
        end
        state_d = ST_CARRY2;
      end
      ST_CARRY2: begin
        acc_d[0] = AccW'(nh_q[0][LimbW-1:0]) + (wrap2 << 2) + wrap2;
        for (int k = 1; k < NumLimbs; k++) begin
          acc_d[k] = AccW'(nh_q[k][LimbW-1:0]) + AccW'(nh_q[k-1][NhW-1:LimbW]);
        end
        state_d = last_q ? ST_FOLD : ST_IDLE;
      end
      ST_FOLD: begin
        v_d     = {1'b0, fold_a} + fold_b;
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        w_d     = {1'b0, v_q[MsgW-1:0]} + (v_q[MsgW] ? (MsgW+1)'(P1305Fold) : '0);
        state_d = ST_SELECT;
      end
      ST_SELECT: begin
        f_d     = sel_g[MsgW] ? sel_g[TagW-1:0] : w_q[TagW-1:0];
        state_d = ST_PAD;
      end
      ST_PAD: begin
        if (tag_write) begin
          tag_d       = f_q + key_i.s;
          tag_valid_d = 1'b1;
          for (int k = 0; k < NumLimbs; k++) begin
            acc_d[k] = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_cnt_q   <= '0;
      last_q      <= 1'b0;
      tag_valid_q <= 1'b0;
      acc_q       <= '{default: '0};
    end else begin
      state_q     <= state_d;
      mul_cnt_q   <= mul_cnt_d;
      last_q      <= last_d;
      tag_valid_q <= tag_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    p_q   <= p_d;
    d_q   <= d_d;
    nh_q  <= nh_d;
    v_q   <= v_d;
    w_q   <= w_d;
    f_q   <= f_d;
    tag_q <= tag_d;
    for (int k = 0; k < NumLimbs; k++) begin
      r_q[k]  <= r_clamped[k*LimbW +: LimbW];
      r5_q[k] <= (CoefW'(r_clamped[k*LimbW +: LimbW]) << 2)
                 + CoefW'(r_clamped[k*LimbW +: LimbW]);
    end
  end

  assign tag_valid_o = tag_valid_q;
  assign tag_o       = tag_q;

  always_comb begin
    acc_zero     = 1'b1;
    acc_bound_ok = 1'b1;
    for (int k = 0; k < NumLimbs; k++) begin
      acc_zero = acc_zero && (acc_q[k] == '0);
      if (acc_q[k][LimbW] && (acc_q[k][LimbW-1:HeadroomW] != '0)) begin
        acc_bound_ok = 1'b0;
      end
    end
  end

  a_tag_from_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tag_valid_q) |-> $past(state_q) == ST_PAD)
    else $error("Tag appeared outside the pad-add step.");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_write |=> acc_zero)
    else $error("Accumulator not cleared after a tag.");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CARRY2) |=> acc_bound_ok)
    else $error("Accumulator limb exceeds its carry headroom.");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> mul_cnt_q <= LastMulStep)
    else $error("Multiply step counter out of range.");

endmodule

`default_nettype wire

@@ rtl/poly1305_mac_engine.sv @@
// Poly1305 authenticator, one 16-byte message block per input item.
// Configuration: write r_low, r_high, pad_low and pad_high through cfg_we_i,
// cfg_index_i and cfg_data_i while no message is in flight. The key is kept
// across messages. Input items (in_valid_i/in_ready_o) carry a block, its
// byte count and a last flag. The item with is_last_i set produces one tag
// on out_valid_o/out_ready_i, after which the accumulator starts from zero.
// Accepted items wait in a queue of FifoDepth entries, so the input stays
// ready while the arithmetic works and while a finished tag waits for the
// receiver, until the queue is full.
// Each absorbing item goes through the arithmetic unit as one load, five
// multiply steps through a row of five 28x29-bit multipliers plus one drain
// step, and two carry passes. The accumulator feeds back into the next item,
// so the unit takes a new block only after the last one has left the carry
// passes. A last item then goes through final reduction and pad addition in
// the fold, reduce, select and pad steps; an empty last item goes to them.
// If the receiver stalls, the tag is held in the output register and the
// arithmetic waits only when a second tag is ready. Reset clears the key,
// the pad, the accumulator and the queue.
`default_nettype none

module poly1305_mac_engine #(
  parameter int FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] block_low_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [4:0]  block_bytes_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      tag_low_o,
  output logic [63:0]      tag_high_o
);
  import p1305_pkg::*;

  logic [63:0]  r_low_q, r_high_q, pad_low_q, pad_high_q;
  p1305_key_t   key;
  p1305_item_t  front_item, queue_item;
  logic         queue_full, queue_empty, queue_pop;
  logic [127:0] tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_low_q    <= '0;
      r_high_q   <= '0;
      pad_low_q  <= '0;
      pad_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_R_LOW:    r_low_q    <= cfg_data_i;
        REG_R_HIGH:   r_high_q   <= cfg_data_i;
        REG_PAD_LOW:  pad_low_q  <= cfg_data_i;
        REG_PAD_HIGH: pad_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key.r = {r_high_q, r_low_q};
  assign key.s = {pad_high_q, pad_low_q};

  p1305_front u_front (
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .block_bytes_i (block_bytes_i),
    .is_last_i     (is_last_i),
    .item_o        (front_item)
  );

  assign in_ready_o = !queue_full;

  p1305_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && in_ready_o),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .item_o  (queue_item),
    .empty_o (queue_empty)
  );

  p1305_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key),
    .item_i       (queue_item),
    .item_valid_i (!queue_empty),
    .item_pop_o   (queue_pop),
    .tag_valid_o  (out_valid_o),
    .tag_ready_i  (out_ready_i),
    .tag_o        (tag)
  );

  assign tag_low_o  = tag[63:0];
  assign tag_high_o = tag[127:64];

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;
  import p1305_pkg::*;

  localparam int NumDirected   = 20;
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 110;
  localparam int PressureTags  = 30;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 40;
  localparam int StallLimit    = 3000;
  localparam logic [63:0] Ones = 64'hffff_ffff_ffff_ffff;
  localparam logic [260:0] PolyPrime = (261'd1 << 130) - 261'd5;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } tag_t;

  typedef struct {
    int          key_sel;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  nbytes;
    logic        is_last;
    bit          typed;
    logic [63:0] exp_lo;
    logic [63:0] exp_hi;
  } block_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = '0;
  logic [63:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [63:0] block_low_i   = '0;
  logic [63:0] block_high_i  = '0;
  logic [4:0]  block_bytes_i = '0;
  logic        is_last_i     = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [63:0] tag_low_o;
  logic [63:0] tag_high_o;

  logic [63:0] key_reg [4] = '{default: '0};
  logic [129:0] acc_h = '0;
  tag_t expected_tags [$];

  int unsigned mismatch_count = 0;
  int unsigned tags_checked   = 0;
  int unsigned blocks_sent    = 0;
  int unsigned messages_sent  = 0;
  int unsigned key_settings   = 0;
  int unsigned burst_left     = 10;
  bit          offering       = 1'b0;
  bit          pressure_req   = 1'b0;

  logic [63:0] directed_keys [3][4] = '{
    '{64'd0, 64'd0, 64'd0, 64'd0},
    '{Ones, Ones, Ones, Ones},
    '{64'h336d_5557_78be_d685, 64'ha806_d542_fe52_447f,
      64'hfdb2_0dfb_8a80_0301, 64'h1bf5_4941_aff6_bf4a}
  };

  block_row_t directed_rows [NumDirected] = '{
    '{0, Ones, Ones, 5'd16, 1'b1, 1'b1, 64'd0, 64'd0},
    '{0, 64'd0, 64'd0, 5'd0, 1'b1, 1'b1, 64'd0, 64'd0},
    '{1, 64'd0, 64'd0, 5'd0, 1'b1, 1'b1, Ones, Ones},
    '{1, Ones, Ones, 5'd16, 1'b0, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd16, 1'b1, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd1, 1'b1, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd7, 1'b1, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd8, 1'b1, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd9, 1'b1, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd15, 1'b1, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd5, 1'b0, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd0, 1'b0, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd31, 1'b0, 1'b0, 64'd0, 64'd0},
    '{1, 64'd0, 64'd0, 5'd20, 1'b1, 1'b0, 64'd0, 64'd0},
    '{1, Ones, Ones, 5'd0, 1'b1, 1'b1, Ones, Ones},
    '{1, 64'd0, 64'd0, 5'd16, 1'b0, 1'b0, 64'd0, 64'd0},
    '{1, 64'd0, 64'd0, 5'd0, 1'b1, 1'b0, 64'd0, 64'd0},
    '{2, 64'h7267_6f74_7079_7243, 64'h6f46_2063_6968_7061, 5'd16, 1'b0, 1'b0,
      64'd0, 64'd0},
    '{2, 64'h6573_6552_206d_7572, 64'h6f72_4720_6863_7261, 5'd16, 1'b0, 1'b0,
      64'd0, 64'd0},
    '{2, 64'h0000_0000_0000_7075, 64'd0, 5'd2, 1'b1, 1'b0, 64'd0, 64'd0}
  };

  poly1305_mac_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .block_bytes_i (block_bytes_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tag_low_o     (tag_low_o),
    .tag_high_o    (tag_high_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [129:0] mul_mod_prime(input logic [130:0] a,
                                                 input logic [127:0] r);
    logic [260:0] wide;
    wide = 261'(a) * 261'(r);
    wide = wide % PolyPrime;
    return wide[129:0];
  endfunction

  // The accumulator is kept fully reduced, so the tag is simply h + s mod 2^128.
  function automatic void predict_tag(input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [4:0] nbytes, input logic is_last,
                                      output bit has_tag, output tag_t tag);
    logic [127:0] r_clamped;
    logic [127:0] pad_s;
    logic [127:0] blk;
    logic [127:0] keep;
    logic [127:0] sum;
    logic [130:0] msg;
    int unsigned  n;
    r_clamped = {key_reg[REG_R_HIGH], key_reg[REG_R_LOW]} & ClampMask;
    pad_s     = {key_reg[REG_PAD_HIGH], key_reg[REG_PAD_LOW]};
    blk       = {hi, lo};
    n         = (nbytes > 5'd16) ? 16 : int'(nbytes);
    tag       = '0;
    if (n != 0) begin
      if (is_last && n < 16) begin
        keep = (128'd1 << (8 * n)) - 128'd1;
        msg  = 131'(blk & keep) | (131'd1 << (8 * n));
      end else begin
        msg = {3'b001, blk};
      end
      acc_h = mul_mod_prime(131'(acc_h) + msg, r_clamped);
    end
    has_tag = is_last;
    if (is_last) begin
      sum    = acc_h[127:0] + pad_s;
      tag.lo = sum[63:0];
      tag.hi = sum[127:64];
      acc_h  = '0;
    end
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9, 0))
      0: return 64'd0;
      1: return Ones;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(input p1305_reg_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    key_reg[idx] = val;
  endtask

  task automatic write_key(input logic [63:0] r_lo, input logic [63:0] r_hi,
                           input logic [63:0] s_lo, input logic [63:0] s_hi);
    write_reg(REG_R_LOW, r_lo);
    write_reg(REG_R_HIGH, r_hi);
    write_reg(REG_PAD_LOW, s_lo);
    write_reg(REG_PAD_HIGH, s_hi);
    cfg_we_i <= 1'b0;
    key_settings++;
  endtask

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] nbytes, input logic is_last,
                            input bit typed, input tag_t typed_tag);
    bit   has_tag;
    tag_t predicted;
    in_valid_i    <= 1'b1;
    block_low_i   <= lo;
    block_high_i  <= hi;
    block_bytes_i <= nbytes;
    is_last_i     <= is_last;
    offering = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_tag(lo, hi, nbytes, is_last, has_tag, predicted);
    if (has_tag) begin
      expected_tags.push_back(typed ? typed_tag : predicted);
      messages_sent++;
    end
    blocks_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                : $urandom_range(6, 1);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : tag_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    tag_t        want;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_tags.size() == 0) begin
          report_mismatch("tag with no message pending", tag_low_o, 64'd0);
        end else begin
          want = expected_tags.pop_front();
          if (tag_low_o !== want.lo) report_mismatch("tag_low", tag_low_o, want.lo);
          if (tag_high_o !== want.hi) report_mismatch("tag_high", tag_high_o, want.hi);
          tags_checked++;
        end
      end
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left    = HoldCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(2, 0);
        mode_left = $urandom_range(120, 20);
      end
      mode_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(1, 0) == 1);
          default: out_ready_i <= ((tick % 7) >= 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no item moved for %0d cycles.", StallLimit);
    $display("poly1305_mac_engine test failed");
    $finish;
  end

  initial begin : stimulus
    int          cur_key;
    int unsigned phase_items;
    int unsigned nblk;
    logic [4:0]  nb;
    logic [63:0] k [4];
    cur_key = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].key_sel != cur_key) begin
        cur_key = directed_rows[i].key_sel;
        wait_idle();
        write_key(directed_keys[cur_key][0], directed_keys[cur_key][1],
                  directed_keys[cur_key][2], directed_keys[cur_key][3]);
      end
      send_block(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].nbytes,
                 directed_rows[i].is_last, directed_rows[i].typed,
                 {directed_rows[i].exp_hi, directed_rows[i].exp_lo});
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      foreach (k[j]) k[j] = rand_word();
      case (phase)
        0: begin
          k[0] = Ones;
          k[1] = Ones;
          k[2] = 64'd0;
          k[3] = 64'd0;
        end
        1: begin
          k[0] = 64'd0;
          k[1] = 64'd0;
        end
        2: begin
          k[0] = ClampMask[63:0];
          k[1] = ClampMask[127:64];
          k[2] = Ones;
          k[3] = Ones;
        end
        default: ;
      endcase
      write_key(k[0], k[1], k[2], k[3]);

      // One-block messages while the receiver holds off, so the input backs up.
      if (phase == 3) begin
        pressure_req = 1'b1;
        repeat (PressureTags) begin
          send_block(rand_word(), rand_word(), 5'($urandom_range(16, 0)), 1'b1,
                     1'b0, '0);
        end
      end

      phase_items = 0;
      while (phase_items < PhaseItems) begin
        nblk = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 5)
                                           : $urandom_range(4, 0);
        repeat (nblk) begin
          nb = ($urandom_range(9, 0) == 0) ? 5'($urandom_range(31, 0)) : 5'd16;
          send_block(rand_word(), rand_word(), nb, 1'b0, 1'b0, '0);
        end
        nb = ($urandom_range(19, 0) == 0) ? 5'($urandom_range(31, 17))
                                          : 5'($urandom_range(16, 0));
        send_block(rand_word(), rand_word(), nb, 1'b1, 1'b0, '0);
        phase_items += nblk + 1;
      end
    end

    wait_idle();
    $display("Sent %0d blocks in %0d messages under %0d key settings.",
             blocks_sent, messages_sent, key_settings);
    $display("Checked %0d tags, %0d mismatches.", tags_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("poly1305_mac_engine test passed");
    end else begin
      $display("poly1305_mac_engine test failed");
    end
    $finish;
  end

endmodule
